// File: src/flv_tdmx_pkg.sv
// Shared types and constants for the FLV tag demultiplexer.
// Used by the core; the channel interfaces only mirror its widths. Depends on nothing.
package flv_tdmx_pkg;

    // Tag type codes as they appear in the tag header.
    localparam logic [7:0] TYPE_AUDIO  = 8'd8;
    localparam logic [7:0] TYPE_VIDEO  = 8'd9;
    localparam logic [7:0] TYPE_SCRIPT = 8'd18;

    // Byte counts and byte indexes of the fixed parts of the file.
    localparam logic [31:0] HDR_LEN       = 32'd9;
    localparam logic [31:0] OFFSET_FIRST  = 32'd5;
    localparam logic [31:0] PREV_SIZE_LEN = 32'd4;
    localparam logic [31:0] TAG_HDR_LAST  = 32'd10;
    localparam logic [31:0] SIZE_LAST     = 32'd3;
    localparam logic [31:0] TIME_LAST     = 32'd6;

    // Preamble burst: nine header bytes, four zero bytes, then the type byte.
    localparam int unsigned HDR_DEPTH = 9;
    localparam logic [3:0]  PRE_ZERO_FIRST = 4'd9;
    localparam logic [3:0]  PRE_LAST       = 4'd13;

    localparam logic [1:0] DEST_NONE  = 2'd0;
    localparam logic [1:0] DEST_AUDIO = 2'd1;
    localparam logic [1:0] DEST_VIDEO = 2'd2;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_TAG   = 2'd1;
    localparam logic [1:0] EV_AUDIO = 2'd2;
    localparam logic [1:0] EV_VIDEO = 2'd3;

    localparam logic [1:0] KIND_AUDIO   = 2'd0;
    localparam logic [1:0] KIND_VIDEO   = 2'd1;
    localparam logic [1:0] KIND_SCRIPT  = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // Register indexes on the configuration port (paddr[2]).
    localparam logic REG_AUDIO_EN = 1'b0;
    localparam logic REG_VIDEO_EN = 1'b1;

    typedef enum logic [7:0] {
        PH_FILEHDR  = 8'b0000_0001,
        PH_OFFSKIP  = 8'b0000_0010,
        PH_PREVSIZE = 8'b0000_0100,
        PH_TAGHDR   = 8'b0000_1000,
        PH_AUDDESC  = 8'b0001_0000,
        PH_AUDDATA  = 8'b0010_0000,
        PH_VIDDATA  = 8'b0100_0000,
        PH_SKIPDATA = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  out_dest;
        logic        last_of_run;
        logic [1:0]  tag_event;
        logic [1:0]  tag_kind;
        logic [23:0] tag_size;
        logic [23:0] tag_time;
        logic [31:0] prev_tag_size;
        logic [3:0]  desc_high;
        logic [3:0]  desc_low;
    } t_result;

    function automatic logic [1:0] kind_of(input logic [7:0] tag_type);
        logic [1:0] k;
        if (tag_type == TYPE_AUDIO) begin
            k = KIND_AUDIO;
        end else if (tag_type == TYPE_VIDEO) begin
            k = KIND_VIDEO;
        end else if (tag_type == TYPE_SCRIPT) begin
            k = KIND_SCRIPT;
        end else begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

endpackage

// File: src/flv_tdmx_in_if.sv
// Input byte channel of the FLV tag demultiplexer: valid/ready plus one file byte.
// Depends on flv_tdmx_pkg only by convention; carries plain vectors.
interface flv_tdmx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// File: src/flv_tdmx_out_if.sv
// Result channel of the FLV tag demultiplexer: valid/ready plus the result fields.
// Field widths follow t_result in flv_tdmx_pkg.
interface flv_tdmx_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  out_dest;
    logic        last_of_run;
    logic [1:0]  tag_event;
    logic [1:0]  tag_kind;
    logic [23:0] tag_size;
    logic [23:0] tag_time;
    logic [31:0] prev_tag_size;
    logic [3:0]  desc_high;
    logic [3:0]  desc_low;

    modport source (output valid, output out_byte, output out_dest, output last_of_run,
                    output tag_event, output tag_kind, output tag_size, output tag_time,
                    output prev_tag_size, output desc_high, output desc_low, input ready);
    modport sink   (input valid, input out_byte, input out_dest, input last_of_run,
                    input tag_event, input tag_kind, input tag_size, input tag_time,
                    input prev_tag_size, input desc_high, input desc_low, output ready);
endinterface

// File: src/flv_tag_demux_core.sv
// FLV tag demultiplexer top level: byte parser, preamble burst and result register.
// Depends on flv_tdmx_pkg, flv_tdmx_in_if and flv_tdmx_out_if.
//
// Takes one FLV file byte per cycle while the result register is free and returns each
// result in the cycle after the byte that causes it, through a single result register; a
// new byte is taken in the same cycle that the waiting result is taken. The one exception
// is the type byte of the first video tag routed to the video stream: it opens a
// 14-transaction burst (stored 9-byte file header, four zero bytes, then the type byte)
// drained one per cycle unless the result is stalled; input is held off until it ends.
// The two extract enables sit at byte addresses 0 (audio) and 4 (video).
module flv_tag_demux_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    flv_tdmx_in_if.sink             i_in,
    flv_tdmx_out_if.source          o_res,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import flv_tdmx_pkg::*;

    // Configuration.
    logic r_aud_en;
    logic r_vid_en;
    logic cfg_wr;

    // Parser state.
    t_phase      r_phase, n_phase;
    logic [31:0] r_bc, n_bc;
    logic [31:0] r_off, n_off;
    logic [31:0] r_prev, n_prev;
    logic [7:0]  r_type, n_type;
    logic [23:0] r_size, n_size;
    logic [23:0] r_time, n_time;
    logic        r_vstart, n_vstart;
    logic        r_route, n_route;
    logic [7:0]  r_hdr [HDR_DEPTH];

    // Preamble burst.
    logic        r_burst_act;
    logic [3:0]  r_burst_cnt;
    logic [7:0]  r_burst_byte;

    // Result register.
    logic        r_out_valid;
    t_result     r_out;

    logic        out_free;
    logic        accept;
    logic [7:0]  b;
    logic [31:0] bc_inc;
    logic [31:0] bc_dec;
    logic        fwd;
    logic        pre;
    logic        res_v;
    logic [1:0]  res_dest;
    logic [1:0]  res_ev;
    logic [7:0]  res_d;
    t_result     step_res;
    t_result     burst_res;
    t_result     pre_res;
    logic [7:0]  burst_data;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_VIDEO_EN) ? {31'd0, r_vid_en} : {31'd0, r_aud_en};

    assign out_free = !r_out_valid || o_res.ready;
    assign i_in.ready = out_free && !r_burst_act;
    assign accept   = i_in.valid && i_in.ready;
    assign b        = i_in.in_byte;
    assign bc_inc   = r_bc + 32'd1;
    assign bc_dec   = r_bc - 32'd1;

    always_comb begin
        n_phase  = r_phase;
        n_bc     = r_bc;
        n_off    = r_off;
        n_prev   = r_prev;
        n_type   = r_type;
        n_size   = r_size;
        n_time   = r_time;
        n_vstart = r_vstart;
        n_route  = r_route;
        res_v    = 1'b0;
        res_dest = DEST_NONE;
        res_ev   = EV_NONE;
        res_d    = 8'd0;
        pre      = 1'b0;
        fwd      = 1'b0;
        case (r_phase)
            PH_FILEHDR: begin
                if (r_bc >= OFFSET_FIRST) begin
                    n_off = {r_off[23:0], b};
                end
                n_bc = bc_inc;
                if (bc_inc >= HDR_LEN) begin
                    if (n_off <= HDR_LEN) begin
                        n_phase = PH_PREVSIZE;
                        n_bc    = 32'd0;
                        n_route = 1'b0;
                    end else begin
                        n_phase = PH_OFFSKIP;
                        n_bc    = HDR_LEN;
                    end
                end
            end
            PH_OFFSKIP: begin
                n_bc = bc_inc;
                if (bc_inc >= r_off) begin
                    n_phase = PH_PREVSIZE;
                    n_bc    = 32'd0;
                    n_route = 1'b0;
                end
            end
            PH_PREVSIZE: begin
                if (r_route && r_vid_en) begin
                    res_v    = 1'b1;
                    res_dest = DEST_VIDEO;
                end
                n_prev = {r_prev[23:0], b};
                n_bc   = bc_inc;
                if (bc_inc >= PREV_SIZE_LEN) begin
                    n_phase = PH_TAGHDR;
                    n_bc    = 32'd0;
                    n_route = 1'b0;
                end
            end
            PH_TAGHDR: begin
                if (r_bc == 32'd0) begin
                    n_type = b;
                    n_size = 24'd0;
                    n_time = 24'd0;
                    if (b == TYPE_VIDEO && r_vid_en && !r_vstart) begin
                        pre      = 1'b1;
                        n_vstart = 1'b1;
                    end
                end else if (r_bc <= SIZE_LAST) begin
                    n_size = {r_size[15:0], b};
                end else if (r_bc <= TIME_LAST) begin
                    n_time = {r_time[15:0], b};
                end
                fwd = (n_type == TYPE_VIDEO) && r_vid_en;
                if (r_bc >= TAG_HDR_LAST) begin
                    res_v    = 1'b1;
                    res_dest = fwd ? DEST_VIDEO : DEST_NONE;
                    res_ev   = EV_TAG;
                    if (r_size == 24'd0) begin
                        n_phase = PH_PREVSIZE;
                        n_bc    = 32'd0;
                        n_route = (r_type == TYPE_VIDEO);
                    end else begin
                        n_bc = {8'd0, r_size};
                        if (r_type == TYPE_AUDIO) begin
                            n_phase = PH_AUDDESC;
                        end else if (r_type == TYPE_VIDEO) begin
                            n_phase = PH_VIDDATA;
                        end else begin
                            n_phase = PH_SKIPDATA;
                        end
                    end
                end else begin
                    if (fwd) begin
                        res_v    = 1'b1;
                        res_dest = DEST_VIDEO;
                    end
                    n_bc = bc_inc;
                end
            end
            PH_AUDDESC: begin
                // The first audio byte is reported as a descriptor and never forwarded.
                res_v  = 1'b1;
                res_ev = EV_AUDIO;
                res_d  = b;
                if (r_bc <= 32'd1) begin
                    n_phase = PH_PREVSIZE;
                    n_bc    = 32'd0;
                    n_route = 1'b0;
                end else begin
                    n_bc    = bc_dec;
                    n_phase = PH_AUDDATA;
                end
            end
            PH_AUDDATA: begin
                if (r_aud_en) begin
                    res_v    = 1'b1;
                    res_dest = DEST_AUDIO;
                end
                if (r_bc <= 32'd1) begin
                    n_phase = PH_PREVSIZE;
                    n_bc    = 32'd0;
                    n_route = 1'b0;
                end else begin
                    n_bc = bc_dec;
                end
            end
            PH_VIDDATA: begin
                if (r_bc == {8'd0, r_size}) begin
                    res_v    = 1'b1;
                    res_dest = r_vid_en ? DEST_VIDEO : DEST_NONE;
                    res_ev   = EV_VIDEO;
                    res_d    = b;
                end else if (r_vid_en) begin
                    res_v    = 1'b1;
                    res_dest = DEST_VIDEO;
                end
                if (r_bc <= 32'd1) begin
                    n_phase = PH_PREVSIZE;
                    n_bc    = 32'd0;
                    n_route = 1'b1;
                end else begin
                    n_bc = bc_dec;
                end
            end
            PH_SKIPDATA: begin
                if (r_bc <= 32'd1) begin
                    n_phase = PH_PREVSIZE;
                    n_bc    = 32'd0;
                    n_route = 1'b0;
                end else begin
                    n_bc = bc_dec;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Result of a single-result byte; tag fields come from the tag being parsed.
    always_comb begin
        step_res.out_byte      = (res_dest != DEST_NONE) ? b : 8'd0;
        step_res.out_dest      = res_dest;
        step_res.last_of_run   = 1'b1;
        step_res.tag_event     = res_ev;
        step_res.tag_kind      = (res_ev != EV_NONE) ? kind_of(r_type) : KIND_AUDIO;
        step_res.tag_size      = (res_ev != EV_NONE) ? r_size : 24'd0;
        step_res.tag_time      = (res_ev != EV_NONE) ? r_time : 24'd0;
        step_res.prev_tag_size = (res_ev != EV_NONE) ? r_prev : 32'd0;
        step_res.desc_high     = (res_ev >= EV_AUDIO) ? res_d[7:4] : 4'd0;
        step_res.desc_low      = (res_ev >= EV_AUDIO) ? res_d[3:0] : 4'd0;
    end

    // Burst entry at r_burst_cnt: header bytes, then zeros, then the saved type byte.
    always_comb begin
        if (r_burst_cnt < PRE_ZERO_FIRST) begin
            burst_data = r_hdr[r_burst_cnt];
        end else if (r_burst_cnt == PRE_LAST) begin
            burst_data = r_burst_byte;
        end else begin
            burst_data = 8'd0;
        end
        burst_res               = '0;
        burst_res.out_byte      = burst_data;
        burst_res.out_dest      = DEST_VIDEO;
        burst_res.last_of_run   = (r_burst_cnt == PRE_LAST);
        pre_res                 = '0;
        pre_res.out_byte        = r_hdr[0];
        pre_res.out_dest        = DEST_VIDEO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aud_en <= 1'b1;
            r_vid_en <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_AUDIO_EN) begin
                r_aud_en <= pwdata[0];
            end else begin
                r_vid_en <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FILEHDR;
            r_bc     <= 32'd0;
            r_off    <= 32'd0;
            r_prev   <= 32'd0;
            r_type   <= 8'd0;
            r_size   <= 24'd0;
            r_time   <= 24'd0;
            r_vstart <= 1'b0;
            r_route  <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_bc     <= n_bc;
            r_off    <= n_off;
            r_prev   <= n_prev;
            r_type   <= n_type;
            r_size   <= n_size;
            r_time   <= n_time;
            r_vstart <= n_vstart;
            r_route  <= n_route;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_phase == PH_FILEHDR) begin
            r_hdr[r_bc[3:0]] <= b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_act <= 1'b0;
            r_burst_cnt <= 4'd0;
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            if (r_burst_act) begin
                r_out_valid <= 1'b1;
                r_out       <= burst_res;
                r_burst_cnt <= r_burst_cnt + 4'd1;
                if (r_burst_cnt == PRE_LAST) begin
                    r_burst_act <= 1'b0;
                end
            end else if (accept && pre) begin
                // Header byte 0 goes out now; the rest follow from the burst counter.
                r_out_valid         <= 1'b1;
                r_out               <= pre_res;
                r_burst_act         <= 1'b1;
                r_burst_cnt         <= 4'd1;
                r_burst_byte        <= b;
            end else if (accept && res_v) begin
                r_out_valid <= 1'b1;
                r_out       <= step_res;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.out_byte      = r_out.out_byte;
    assign o_res.out_dest      = r_out.out_dest;
    assign o_res.last_of_run   = r_out.last_of_run;
    assign o_res.tag_event     = r_out.tag_event;
    assign o_res.tag_kind      = r_out.tag_kind;
    assign o_res.tag_size      = r_out.tag_size;
    assign o_res.tag_time      = r_out.tag_time;
    assign o_res.prev_tag_size = r_out.prev_tag_size;
    assign o_res.desc_high     = r_out.desc_high;
    assign o_res.desc_low      = r_out.desc_low;

endmodule

// File: src/flv_tdmx_chk.sv
// Port-level checker for flv_tag_demux_core, attached by the bind at the end.
// Sees only the top level's ports; depends on no package.
module flv_tdmx_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [7:0]  i_out_byte,
    input logic [1:0]  i_out_dest,
    input logic [1:0]  i_tag_event,
    input logic [1:0]  i_tag_kind,
    input logic [23:0] i_tag_size,
    input logic [31:0] i_prev_tag_size,
    input logic [3:0]  i_desc_high,
    input logic [3:0]  i_desc_low,
    input logic        i_pready
);

    // A stalled result keeps its byte.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_out_byte))
        else $error("result changed while stalled");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_out_dest == 2'd0 |-> i_out_byte == 8'd0)
        else $error("byte set on unrouted result");

    a_no_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_tag_event == 2'd0 |->
            i_tag_kind == 2'd0 && i_tag_size == 24'd0 && i_prev_tag_size == 32'd0)
        else $error("tag fields set without an event");

    // A result with no event or with a tag event carries no descriptor nibbles.
    a_hdr_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_tag_event == 2'd0 || i_tag_event == 2'd1) |->
            i_desc_high == 4'd0 && i_desc_low == 4'd0)
        else $error("descriptor nibbles set outside a descriptor event");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("pready dropped");

endmodule

bind flv_tag_demux_core flv_tdmx_chk u_flv_tdmx_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_out_byte     (o_res.out_byte),
    .i_out_dest     (o_res.out_dest),
    .i_tag_event    (o_res.tag_event),
    .i_tag_kind     (o_res.tag_kind),
    .i_tag_size     (o_res.tag_size),
    .i_prev_tag_size(o_res.prev_tag_size),
    .i_desc_high    (o_res.desc_high),
    .i_desc_low     (o_res.desc_low),
    .i_pready       (pready)
);
